// ----- src/bes_pkg.sv -----
// Shared constants, control word type and microcode ROM for the breakpoint envelope block.
package bes_pkg;

  localparam int MAX_POINTS = 64;
  localparam int SLOT_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int UCNT_W = (CNT_W > 7) ? CNT_W : 7;
  localparam int DIV_STEPS = 33;
  localparam int DCNT_W = $clog2(DIV_STEPS);
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_INCREMENT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = CFG_IDX_W'(1);
  localparam logic [31:0] INC_RESET = 32'd349;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_RESTART = 2'd1;
  localparam logic [1:0] FUNC_SAMPLE = 2'd2;

  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NOP = 4'd0;
  localparam logic [OP_W-1:0] OP_WAIT = 4'd1;
  localparam logic [OP_W-1:0] OP_DIFF = 4'd2;
  localparam logic [OP_W-1:0] OP_MUL = 4'd3;
  localparam logic [OP_W-1:0] OP_DIVINIT = 4'd4;
  localparam logic [OP_W-1:0] OP_DIVSTEP = 4'd5;
  localparam logic [OP_W-1:0] OP_SUM = 4'd6;
  localparam logic [OP_W-1:0] OP_RES_RIGHT = 4'd7;
  localparam logic [OP_W-1:0] OP_TADD = 4'd8;
  localparam logic [OP_W-1:0] OP_ADVANCE = 4'd9;
  localparam logic [OP_W-1:0] OP_LOAD_LEFT = 4'd10;
  localparam logic [OP_W-1:0] OP_LOAD_RIGHT = 4'd11;
  localparam logic [OP_W-1:0] OP_EMIT = 4'd12;
  localparam logic [OP_W-1:0] OP_RES_ZERO = 4'd13;
  localparam logic [OP_W-1:0] OP_RES_LEFT = 4'd14;
  localparam logic [OP_W-1:0] OP_WRITE = 4'd15;

  localparam logic [1:0] ADDR_NONE = 2'd0;
  localparam logic [1:0] ADDR_ZERO = 2'd1;
  localparam logic [1:0] ADDR_ONE = 2'd2;
  localparam logic [1:0] ADDR_SLOT = 2'd3;

  localparam int COND_W = 4;
  localparam logic [COND_W-1:0] C_NONE = 4'd0;
  localparam logic [COND_W-1:0] C_ALWAYS = 4'd1;
  localparam logic [COND_W-1:0] C_NO_REQ = 4'd2;
  localparam logic [COND_W-1:0] C_FUNC_WR = 4'd3;
  localparam logic [COND_W-1:0] C_FUNC_RST = 4'd4;
  localparam logic [COND_W-1:0] C_NOT_SMP = 4'd5;
  localparam logic [COND_W-1:0] C_FEW = 4'd6;
  localparam logic [COND_W-1:0] C_HOLD = 4'd7;
  localparam logic [COND_W-1:0] C_WZERO = 4'd8;
  localparam logic [COND_W-1:0] C_DIV_MORE = 4'd9;
  localparam logic [COND_W-1:0] C_NOT_PAST = 4'd10;
  localparam logic [COND_W-1:0] C_OUT_BUSY = 4'd11;

  localparam int PC_W = 5;
  localparam logic [PC_W-1:0] S_IDLE = 5'd0;
  localparam logic [PC_W-1:0] S_DIV = 5'd8;
  localparam logic [PC_W-1:0] S_ZW = 5'd10;
  localparam logic [PC_W-1:0] S_TADD = 5'd11;
  localparam logic [PC_W-1:0] S_EMIT = 5'd16;
  localparam logic [PC_W-1:0] S_FEW = 5'd18;
  localparam logic [PC_W-1:0] S_HOLDV = 5'd19;
  localparam logic [PC_W-1:0] S_WR = 5'd20;
  localparam logic [PC_W-1:0] S_RST = 5'd21;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [1:0] addr_sel;
    logic [COND_W-1:0] cond;
    logic [PC_W-1:0] target;
  } ucw_t;

  function automatic ucw_t ucode(input logic [PC_W-1:0] pc);
    ucw_t w;
    unique case (pc)
      5'd0: w = '{OP_WAIT, ADDR_NONE, C_NO_REQ, S_IDLE};
      5'd1: w = '{OP_NOP, ADDR_NONE, C_FUNC_WR, S_WR};
      5'd2: w = '{OP_NOP, ADDR_NONE, C_FUNC_RST, S_RST};
      5'd3: w = '{OP_NOP, ADDR_NONE, C_NOT_SMP, S_IDLE};
      5'd4: w = '{OP_NOP, ADDR_NONE, C_FEW, S_FEW};
      5'd5: w = '{OP_DIFF, ADDR_NONE, C_HOLD, S_HOLDV};
      5'd6: w = '{OP_MUL, ADDR_NONE, C_WZERO, S_ZW};
      5'd7: w = '{OP_DIVINIT, ADDR_NONE, C_NONE, S_IDLE};
      5'd8: w = '{OP_DIVSTEP, ADDR_NONE, C_DIV_MORE, S_DIV};
      5'd9: w = '{OP_SUM, ADDR_NONE, C_ALWAYS, S_TADD};
      5'd10: w = '{OP_RES_RIGHT, ADDR_NONE, C_NONE, S_IDLE};
      5'd11: w = '{OP_TADD, ADDR_NONE, C_NONE, S_IDLE};
      5'd12: w = '{OP_NOP, ADDR_SLOT, C_NOT_PAST, S_EMIT};
      5'd13: w = '{OP_ADVANCE, ADDR_NONE, C_NONE, S_IDLE};
      5'd14: w = '{OP_NOP, ADDR_SLOT, C_HOLD, S_EMIT};
      5'd15: w = '{OP_LOAD_RIGHT, ADDR_NONE, C_NONE, S_IDLE};
      5'd16: w = '{OP_EMIT, ADDR_NONE, C_OUT_BUSY, S_EMIT};
      5'd17: w = '{OP_NOP, ADDR_NONE, C_ALWAYS, S_IDLE};
      5'd18: w = '{OP_RES_ZERO, ADDR_NONE, C_ALWAYS, S_EMIT};
      5'd19: w = '{OP_RES_LEFT, ADDR_NONE, C_ALWAYS, S_EMIT};
      5'd20: w = '{OP_WRITE, ADDR_NONE, C_ALWAYS, S_IDLE};
      5'd21: w = '{OP_NOP, ADDR_NONE, C_FEW, S_IDLE};
      5'd22: w = '{OP_NOP, ADDR_ZERO, C_NONE, S_IDLE};
      5'd23: w = '{OP_LOAD_LEFT, ADDR_ONE, C_NONE, S_IDLE};
      5'd24: w = '{OP_LOAD_RIGHT, ADDR_NONE, C_ALWAYS, S_IDLE};
      default: w = '{OP_NOP, ADDR_NONE, C_ALWAYS, S_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ----- src/bes_if.sv -----
// Request and result channel interfaces of the breakpoint envelope block.
interface bes_in_if;
  logic valid;
  logic ready;
  logic [1:0] func;
  logic [5:0] entry_index;
  logic [31:0] entry_time;
  logic signed [31:0] entry_value;

  modport source(output valid, output func, output entry_index, output entry_time,
                 output entry_value, input ready);
  modport sink(input valid, input func, input entry_index, input entry_time,
               input entry_value, output ready);
endinterface

interface bes_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] sample;
  logic segment_active;

  modport source(output valid, output sample, output segment_active, input ready);
  modport sink(input valid, input sample, input segment_active, output ready);
endinterface

// ----- src/bes_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module bes_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/breakpoint_envelope_stream_top.sv -----
// Breakpoint envelope top level: microcoded sequencer, datapath and breakpoint table.
//
// Piecewise-linear envelope over a table of up to 64 breakpoints. One request is
// handled at a time. A sample request forms (offset * height) / width with a single
// 32x32 multiply followed by a 33-step restoring divider that yields one quotient bit
// per cycle, and may then step to the next segment or run off the end of the table.
// Short-table, holding and zero-width samples skip the divider. A result waits in an
// output register, so the next request can be taken while it is still pending; the
// emit step stalls only while the previous result has not been taken. Configuration
// writes land at once and must only be issued while no request is in flight.
module breakpoint_envelope_stream_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [bes_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                    cfg_data,
  bes_in_if.sink                         request,
  bes_out_if.source                      result
);

  localparam int UW = bes_pkg::UCNT_W;
  localparam int SW = bes_pkg::SLOT_W;

  logic [31:0] sample_increment;
  logic [6:0] point_count;
  logic [bes_pkg::PC_W-1:0] pc;
  logic [bes_pkg::PC_W-1:0] pc_next;
  bes_pkg::ucw_t ucw;

  logic [1:0] func_r;
  logic [5:0] idx_r;
  logic [31:0] etime_r;
  logic [31:0] evalue_r;

  logic [31:0] current_time;
  logic [31:0] left_time;
  logic [31:0] left_value;
  logic [31:0] right_time;
  logic [31:0] right_value;
  logic [UW-1:0] right_slot;
  logic more_points;

  logic [31:0] wmag;
  logic [31:0] omag;
  logic [31:0] hmag;
  logic neg;
  logic wzero;
  logic [63:0] prod;
  logic sat;
  logic [31:0] rem;
  logic [32:0] dq;
  logic [bes_pkg::DCNT_W-1:0] dcnt;
  logic [31:0] res;
  logic act;

  logic out_valid;
  logic [31:0] out_sample;
  logic out_active;

  logic accept;
  logic taken;
  logic out_busy;
  logic [UW-1:0] pcount_x;
  logic [UW-1:0] used_count;
  logic few;

  logic [32:0] w_diff;
  logic [32:0] o_diff;
  logic [32:0] h_diff;
  logic [32:0] w_negd;
  logic [32:0] o_negd;
  logic [32:0] h_negd;
  logic [32:0] t_sum;
  logic [31:0] t_sat;
  logic [32:0] trial;
  logic [32:0] trial_sub;
  logic trial_ge;
  logic [34:0] q_ext;
  logic [34:0] lv_ext;
  logic [34:0] s_sum;
  logic [31:0] s_sat;
  logic [UW-1:0] slot_inc;

  logic ram_we;
  logic [SW-1:0] ram_waddr;
  logic [SW-1:0] ram_raddr;
  logic [63:0] ram_rdata;

  assign ucw = bes_pkg::ucode(pc);
  assign request.ready = (ucw.op == bes_pkg::OP_WAIT) && !rst;
  assign accept = request.valid && request.ready;
  assign out_busy = out_valid && !result.ready;

  assign result.valid = out_valid;
  assign result.sample = out_sample;
  assign result.segment_active = out_active;

  assign pcount_x = UW'(point_count);
  assign used_count = (pcount_x > UW'(bes_pkg::MAX_POINTS)) ? UW'(bes_pkg::MAX_POINTS)
                                                            : pcount_x;
  assign few = used_count < UW'(2);

  always_comb begin
    unique case (ucw.cond)
      bes_pkg::C_NONE: taken = 1'b0;
      bes_pkg::C_ALWAYS: taken = 1'b1;
      bes_pkg::C_NO_REQ: taken = !accept;
      bes_pkg::C_FUNC_WR: taken = (func_r == bes_pkg::FUNC_WRITE);
      bes_pkg::C_FUNC_RST: taken = (func_r == bes_pkg::FUNC_RESTART);
      bes_pkg::C_NOT_SMP: taken = (func_r != bes_pkg::FUNC_SAMPLE);
      bes_pkg::C_FEW: taken = few;
      bes_pkg::C_HOLD: taken = !more_points;
      bes_pkg::C_WZERO: taken = wzero;
      bes_pkg::C_DIV_MORE: taken = (dcnt != '0);
      bes_pkg::C_NOT_PAST: taken = (current_time <= right_time);
      bes_pkg::C_OUT_BUSY: taken = out_busy;
      default: taken = 1'b0;
    endcase
    pc_next = taken ? ucw.target : pc + bes_pkg::PC_W'(1);
  end

  always_comb begin
    w_diff = {1'b0, right_time} - {1'b0, left_time};
    o_diff = {1'b0, current_time} - {1'b0, left_time};
    h_diff = {right_value[31], right_value} - {left_value[31], left_value};
    w_negd = 33'd0 - w_diff;
    o_negd = 33'd0 - o_diff;
    h_negd = 33'd0 - h_diff;
    t_sum = {1'b0, current_time} + {1'b0, sample_increment};
    t_sat = t_sum[32] ? 32'hFFFF_FFFF : t_sum[31:0];
    trial = {rem, dq[32]};
    trial_ge = trial >= {1'b0, wmag};
    trial_sub = trial - {1'b0, wmag};
    q_ext = {2'b00, dq};
    lv_ext = {{3{left_value[31]}}, left_value};
    s_sum = neg ? lv_ext - q_ext : lv_ext + q_ext;
    if (sat) begin
      s_sat = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else if (s_sum[34:31] != {4{s_sum[34]}}) begin
      s_sat = s_sum[34] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      s_sat = s_sum[31:0];
    end
    slot_inc = right_slot + UW'(1);
  end

  always_comb begin
    unique case (ucw.addr_sel)
      bes_pkg::ADDR_ZERO: ram_raddr = '0;
      bes_pkg::ADDR_ONE: ram_raddr = SW'(1);
      bes_pkg::ADDR_SLOT: ram_raddr = right_slot[SW-1:0];
      default: ram_raddr = '0;
    endcase
  end

  assign ram_we = (ucw.op == bes_pkg::OP_WRITE) && (UW'(idx_r) < UW'(bes_pkg::MAX_POINTS));
  assign ram_waddr = SW'(idx_r);

  bes_ram #(
    .WIDTH(64),
    .DEPTH(bes_pkg::MAX_POINTS)
  ) u_table (
    .clk(clk),
    .we(ram_we),
    .waddr(ram_waddr),
    .wdata({etime_r, evalue_r}),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= bes_pkg::S_IDLE;
      sample_increment <= bes_pkg::INC_RESET;
      point_count <= '0;
      out_valid <= 1'b0;
      current_time <= '0;
      left_time <= '0;
      left_value <= '0;
      right_time <= '0;
      right_value <= '0;
      right_slot <= '0;
      more_points <= 1'b0;
    end else begin
      pc <= pc_next;
      if (cfg_write) begin
        unique case (cfg_index)
          bes_pkg::REG_SAMPLE_INCREMENT: sample_increment <= cfg_data;
          bes_pkg::REG_POINT_COUNT: point_count <= cfg_data[6:0];
          default: ;
        endcase
      end
      if (ucw.op == bes_pkg::OP_EMIT && !out_busy) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      if (pc == bes_pkg::S_RST) begin
        current_time <= '0;
        right_slot <= UW'(1);
        left_time <= '0;
        left_value <= '0;
        right_time <= '0;
        right_value <= '0;
        more_points <= !few;
      end
      unique case (ucw.op)
        bes_pkg::OP_TADD: current_time <= t_sat;
        bes_pkg::OP_ADVANCE: begin
          left_time <= ram_rdata[63:32];
          left_value <= ram_rdata[31:0];
          right_slot <= slot_inc;
          more_points <= slot_inc < used_count;
        end
        bes_pkg::OP_LOAD_LEFT: begin
          left_time <= ram_rdata[63:32];
          left_value <= ram_rdata[31:0];
        end
        bes_pkg::OP_LOAD_RIGHT: begin
          right_time <= ram_rdata[63:32];
          right_value <= ram_rdata[31:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= request.func;
      idx_r <= request.entry_index;
      etime_r <= request.entry_time;
      evalue_r <= request.entry_value;
    end
    if (ucw.op == bes_pkg::OP_EMIT && !out_busy) begin
      out_sample <= res;
      out_active <= act;
    end
    unique case (ucw.op)
      bes_pkg::OP_DIFF: begin
        wmag <= w_diff[32] ? w_negd[31:0] : w_diff[31:0];
        omag <= o_diff[32] ? o_negd[31:0] : o_diff[31:0];
        hmag <= h_diff[32] ? h_negd[31:0] : h_diff[31:0];
        neg <= (o_diff[32] ^ h_diff[32]) ^ w_diff[32];
        wzero <= (w_diff == '0);
      end
      bes_pkg::OP_MUL: prod <= omag * hmag;
      bes_pkg::OP_DIVINIT: begin
        sat <= {1'b0, prod[63:33]} >= wmag;
        rem <= {1'b0, prod[63:33]};
        dq <= prod[32:0];
        dcnt <= bes_pkg::DCNT_W'(bes_pkg::DIV_STEPS - 1);
      end
      bes_pkg::OP_DIVSTEP: begin
        rem <= trial_ge ? trial_sub[31:0] : trial[31:0];
        dq <= {dq[31:0], trial_ge};
        dcnt <= dcnt - bes_pkg::DCNT_W'(1);
      end
      bes_pkg::OP_SUM: begin
        res <= s_sat;
        act <= 1'b1;
      end
      bes_pkg::OP_RES_RIGHT: begin
        res <= right_value;
        act <= 1'b1;
      end
      bes_pkg::OP_RES_ZERO: begin
        res <= '0;
        act <= 1'b0;
      end
      bes_pkg::OP_RES_LEFT: begin
        res <= left_value;
        act <= 1'b0;
      end
      default: ;
    endcase
  end

  a_slot_in_range: assert property (@(posedge clk) disable iff (rst)
    more_points |-> right_slot < UW'(bes_pkg::MAX_POINTS))
    else $error("segment active with right slot beyond table");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (pc == bes_pkg::S_DIV && !sat) |-> rem < wmag)
    else $error("divider remainder not below divisor");

  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(pc) == bes_pkg::S_EMIT)
    else $error("result raised outside emit step");

  a_restart_slot: assert property (@(posedge clk) disable iff (rst)
    (pc == bes_pkg::S_RST) |=> right_slot == UW'(1))
    else $error("restart did not set right slot to one");

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for the breakpoint envelope block: random and directed requests.
module testbench;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int ITEM_TARGET = 950;
  localparam int SETTLE_CYCLES = 64;
  localparam int LONG_HOLD = 600;

  typedef struct packed {
    logic [1:0] func;
    logic [5:0] slot;
    logic [31:0] stamp;
    logic [31:0] level;
  } request_t;

  typedef struct packed {
    logic [31:0] level;
    logic active;
  } sample_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_write;
  logic [bes_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;

  bes_in_if req_if();
  bes_out_if res_if();

  breakpoint_envelope_stream_top u_top (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .request(req_if),
    .result(res_if)
  );

  logic [31:0] bp_time [bes_pkg::MAX_POINTS];
  logic [31:0] bp_level [bes_pkg::MAX_POINTS];
  logic [31:0] stream_time = '0;
  logic [31:0] left_t = '0;
  logic [31:0] left_v = '0;
  logic [31:0] right_t = '0;
  logic [31:0] right_v = '0;
  int right_slot = 0;
  bit more_points = 1'b0;
  logic [31:0] env_inc = bes_pkg::INC_RESET;
  logic [6:0] env_count = '0;
  bit slot_written [bes_pkg::MAX_POINTS];

  request_t request_queue [$];
  sample_t expected_samples [$];

  int offered_count = 0;
  int taken_count = 0;
  int mismatch_count = 0;
  int cycle_count = 0;
  int item_total = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;
  int hold_served;
  int hold_left;

  request_t seen;
  sample_t want;
  sample_t got;
  bit emits;

  always #1 clk = ~clk;

  function automatic longint unsigned magnitude(input longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  function automatic logic [31:0] segment_point();
    longint span;
    longint offset;
    longint rise;
    longint sum;
    longint unsigned quot;
    bit neg;
    span = longint'({32'd0, right_t}) - longint'({32'd0, left_t});
    if (span == 0) return right_v;
    offset = longint'({32'd0, stream_time}) - longint'({32'd0, left_t});
    rise = longint'($signed(right_v)) - longint'($signed(left_v));
    neg = ((offset < 0) != (rise < 0)) != (span < 0);
    quot = (magnitude(offset) * magnitude(rise)) / magnitude(span);
    if (quot >= 64'h2_0000_0000) return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    sum = longint'($signed(left_v)) + (neg ? -longint'(quot) : longint'(quot));
    if (sum > 64'sd2147483647) sum = 64'sd2147483647;
    if (sum < -64'sd2147483648) sum = -64'sd2147483648;
    return sum[31:0];
  endfunction

  task automatic envelope_step(input request_t rq, output bit has_sample, output sample_t out);
    int unsigned used;
    longint unsigned next_time;
    used = (env_count > bes_pkg::MAX_POINTS) ? bes_pkg::MAX_POINTS : env_count;
    has_sample = 1'b0;
    out = '0;
    case (rq.func)
      bes_pkg::FUNC_WRITE: begin
        bp_time[rq.slot] = rq.stamp;
        bp_level[rq.slot] = rq.level;
      end
      bes_pkg::FUNC_RESTART: begin
        stream_time = '0;
        right_slot = 1;
        if (used < 2) begin
          left_t = '0;
          left_v = '0;
          right_t = '0;
          right_v = '0;
          more_points = 1'b0;
        end else begin
          left_t = bp_time[0];
          left_v = bp_level[0];
          right_t = bp_time[1];
          right_v = bp_level[1];
          more_points = 1'b1;
        end
      end
      bes_pkg::FUNC_SAMPLE: begin
        has_sample = 1'b1;
        if (used >= 2 && !more_points) begin
          out.level = left_v;
        end else if (used >= 2) begin
          out.level = segment_point();
          out.active = 1'b1;
          next_time = {32'd0, stream_time} + {32'd0, env_inc};
          stream_time = (next_time > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : next_time[31:0];
          if (stream_time > right_t) begin
            left_t = bp_time[right_slot];
            left_v = bp_level[right_slot];
            right_slot++;
            more_points = right_slot < used;
            if (more_points) begin
              right_t = bp_time[right_slot];
              right_v = bp_level[right_slot];
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic push_req(input logic [1:0] func, input logic [5:0] slot,
                          input logic [31:0] stamp, input logic [31:0] level);
    request_t rq;
    rq = '{func, slot, stamp, level};
    request_queue.insert(request_queue.size(), rq);
    if (func == bes_pkg::FUNC_WRITE) slot_written[slot] = 1'b1;
    if (func != FUNC_UNUSED) item_total++;
  endtask

  task automatic push_op(input logic [1:0] func);
    push_req(func, 6'($urandom), $urandom, $urandom);
  endtask

  function automatic logic [31:0] random_level();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($urandom_range(0, 2000)) - 32'd1000;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_table(input int n);
    longint unsigned acc;
    longint unsigned gap;
    int k;
    acc = $urandom_range(1) ? 64'd0 : 64'($urandom_range(0, env_inc));
    for (k = 0; k < n; k++) begin
      push_req(bes_pkg::FUNC_WRITE, 6'(k), (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0],
               random_level());
      gap = env_inc;
      gap = gap * $urandom_range(0, 3) + $urandom_range(0, env_inc);
      if ($urandom_range(7) == 0) gap = 0;
      acc += gap;
    end
  endtask

  task automatic set_reg(input logic [bes_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    if (idx == bes_pkg::REG_SAMPLE_INCREMENT) env_inc = data;
    else env_count = data[6:0];
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic settle();
    while (request_queue.size() != 0 || expected_samples.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (rst) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || taken_count == offered_count) begin
      if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        req_if.valid <= 1'b1;
        req_if.func <= request_queue[0].func;
        req_if.entry_index <= request_queue[0].slot;
        req_if.entry_time <= request_queue[0].stamp;
        req_if.entry_value <= request_queue[0].level;
        offered_count <= offered_count + 1;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) res_if.ready <= 1'b0;
    else res_if.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_served <= 0;
    end else if (hold_served != hold_requests) begin
      hold_left <= LONG_HOLD;
      hold_served <= hold_requests;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (res_if.valid && res_if.ready) begin
        got.level = res_if.sample;
        got.active = res_if.segment_active;
        if (expected_samples.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected sample %h active %b", got.level, got.active);
        end else begin
          want = expected_samples.pop_front();
          if (got.level !== want.level || got.active !== want.active) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("sample mismatch: expected %h active %b, got %h active %b",
                       want.level, want.active, got.level, got.active);
          end
        end
      end
      if (req_if.valid && req_if.ready) begin
        seen = request_queue.pop_front();
        taken_count++;
        envelope_step(seen, emits, want);
        if (emits) expected_samples.insert(expected_samples.size(), want);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int ph;
    int n;
    int r;
    int used;
    int phase_start;
    int s;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    push_op(bes_pkg::FUNC_SAMPLE);
    push_op(FUNC_UNUSED);
    push_op(bes_pkg::FUNC_RESTART);
    push_op(bes_pkg::FUNC_SAMPLE);
    settle();

    set_reg(bes_pkg::REG_SAMPLE_INCREMENT, 32'hFFFF_FFFF);
    set_reg(bes_pkg::REG_POINT_COUNT, 32'd1);
    push_req(bes_pkg::FUNC_WRITE, 6'd0, 32'd0, 32'h7FFF_FFFF);
    push_op(bes_pkg::FUNC_RESTART);
    push_op(bes_pkg::FUNC_SAMPLE);
    settle();

    set_reg(bes_pkg::REG_POINT_COUNT, 32'd2);
    push_req(bes_pkg::FUNC_WRITE, 6'd1, 32'hFFFF_FFFF, 32'h8000_0000);
    push_op(bes_pkg::FUNC_RESTART);
    repeat (3) push_op(bes_pkg::FUNC_SAMPLE);
    push_req(bes_pkg::FUNC_WRITE, 6'd1, 32'd0, 32'h1234_5678);
    push_op(bes_pkg::FUNC_RESTART);
    repeat (2) push_op(bes_pkg::FUNC_SAMPLE);
    push_req(bes_pkg::FUNC_WRITE, 6'd63, 32'hFFFF_FFFF, random_level());
    settle();

    set_reg(bes_pkg::REG_SAMPLE_INCREMENT, 32'd1);
    push_req(bes_pkg::FUNC_WRITE, 6'd0, 32'd10, 32'h7FFF_FFF0);
    push_req(bes_pkg::FUNC_WRITE, 6'd1, 32'd5, 32'h7FFF_FFFF);
    push_op(bes_pkg::FUNC_RESTART);
    repeat (2) push_op(bes_pkg::FUNC_SAMPLE);
    push_req(bes_pkg::FUNC_WRITE, 6'd0, 32'd100, 32'd0);
    push_req(bes_pkg::FUNC_WRITE, 6'd1, 32'd101, 32'h7FFF_FFFF);
    push_op(bes_pkg::FUNC_RESTART);
    push_op(bes_pkg::FUNC_SAMPLE);
    settle();

    ph = 0;
    while (item_total < ITEM_TARGET) begin
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 49; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 49; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      if (ph == 0) begin
        set_reg(bes_pkg::REG_SAMPLE_INCREMENT, 32'd1);
        set_reg(bes_pkg::REG_POINT_COUNT, 32'd64);
      end else if (ph == 1) begin
        set_reg(bes_pkg::REG_SAMPLE_INCREMENT, 32'hFFFF_FFFF);
        set_reg(bes_pkg::REG_POINT_COUNT, 32'd127);
      end else begin
        case ($urandom_range(7))
          0: set_reg(bes_pkg::REG_SAMPLE_INCREMENT, 32'd1);
          1: set_reg(bes_pkg::REG_SAMPLE_INCREMENT, 32'hFFFF_FFFF);
          2: set_reg(bes_pkg::REG_SAMPLE_INCREMENT, $urandom_range(1, 32'hFFFF_FFFF));
          default: set_reg(bes_pkg::REG_SAMPLE_INCREMENT, $urandom_range(1, 5000));
        endcase
        case ($urandom_range(15))
          0: set_reg(bes_pkg::REG_POINT_COUNT, 32'd0);
          1: set_reg(bes_pkg::REG_POINT_COUNT, 32'd1);
          2: set_reg(bes_pkg::REG_POINT_COUNT, 32'd64);
          3: set_reg(bes_pkg::REG_POINT_COUNT, $urandom_range(65, 127));
          default: set_reg(bes_pkg::REG_POINT_COUNT, $urandom_range(2, 8));
        endcase
      end
      if (ph == 2) hold_requests++;
      used = (env_count > bes_pkg::MAX_POINTS) ? bes_pkg::MAX_POINTS : env_count;
      for (s = 0; s < used; s++)
        if (!slot_written[s]) push_req(bes_pkg::FUNC_WRITE, 6'(s), $urandom, random_level());
      phase_start = item_total;
      while (item_total - phase_start < 50) begin
        r = $urandom_range(9);
        if (used < 2) n = $urandom_range(1, 3);
        else n = (used < 8) ? $urandom_range(2, used) : $urandom_range(2, 8);
        if (r < 6) begin
          queue_table(n);
          push_op(bes_pkg::FUNC_RESTART);
          repeat ($urandom_range(2 * n, 5 * n + 2)) push_op(bes_pkg::FUNC_SAMPLE);
        end else if (r < 8) begin
          repeat (6) push_req(2'($urandom_range(3)), 6'($urandom), $urandom, $urandom);
        end else if (r == 8) begin
          queue_table(n);
          repeat ($urandom_range(1, 6)) push_op(bes_pkg::FUNC_SAMPLE);
        end else begin
          push_op(bes_pkg::FUNC_RESTART);
          repeat ($urandom_range(1, 3)) push_op(bes_pkg::FUNC_SAMPLE);
          push_req(bes_pkg::FUNC_WRITE, 6'($urandom_range(0, n - 1)), $urandom,
                   random_level());
          repeat ($urandom_range(1, 4)) push_op(bes_pkg::FUNC_SAMPLE);
        end
      end
      settle();
      ph++;
    end

    if (mismatch_count == 0 && expected_samples.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
